// ===== rtl/core/nhfr_pkg.sv =====
// Shared types and widths for the NRZI HDLC frame receiver core.
`timescale 1ns / 1ps
`default_nettype none

package nhfr_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned COUNT_W = 10;

   localparam logic [1:0] MODE_HUNT  = 2'd0;
   localparam logic [1:0] MODE_LEAD  = 2'd1;
   localparam logic [1:0] MODE_FRAME = 2'd2;

   localparam logic [KIND_W-1:0] EV_DATA       = 2'd0;
   localparam logic [KIND_W-1:0] EV_END        = 2'd1;
   localparam logic [KIND_W-1:0] EV_ABORT_ONES = 2'd2;
   localparam logic [KIND_W-1:0] EV_ABORT_LONG = 2'd3;

   typedef struct packed {
      logic valid;
      logic flip;
   } nhfr_bit_type;

endpackage

`default_nettype wire

// ===== rtl/core/nhfr_front.sv =====
// Front end: NRZI level compare and queue of decoded line bits.
`timescale 1ns / 1ps
`default_nettype none

module nhfr_front
   import nhfr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_line_level,
   output nhfr_bit_type      head,
   input  wire logic         pop
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic              prev_level_ff, prev_level_in;
   logic [QUEUE_DEPTH-1:0] flip_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              take;

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign take       = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.flip  = flip_ff[rd_ptr_ff];

   always_comb begin
      prev_level_in = push ? req_line_level : prev_level_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         prev_level_ff <= prev_level_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // a level change on the line decodes to a 0 bit
   always_ff @(posedge clock) begin
      if (push) begin
         flip_ff[wr_ptr_ff] <= req_line_level ^ prev_level_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/nhfr_back.sv =====
// Back end: flag hunt, bit destuffing, byte assembly and event output register.
`timescale 1ns / 1ps
`default_nettype none

module nhfr_back
   import nhfr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire nhfr_bit_type       head,
   output logic                    pop,
   input  wire logic [COUNT_W-1:0] max_frame_bytes,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [DATA_W-1:0]       rsp_data_byte,
   output logic [KIND_W-1:0]       rsp_event_kind,
   output logic [COUNT_W-1:0]      rsp_byte_position
);

   localparam logic [DATA_W-1:0] FLAG_BYTE = 8'h7E;

   logic [2:0]          ones_ff, ones_in;
   logic [DATA_W-1:0]   shift_ff, shift_in;
   logic [3:0]          bits_ff, bits_in;
   logic [1:0]          mode_ff, mode_in;
   logic [COUNT_W-1:0]  frame_ff, frame_in;
   logic                flag_ff, flag_in;

   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_data_ff;
   logic [KIND_W-1:0]   out_kind_ff;
   logic [COUNT_W-1:0]  out_pos_ff;

   logic                res;
   logic [DATA_W-1:0]   res_data;
   logic [KIND_W-1:0]   res_kind;
   logic [COUNT_W-1:0]  res_pos;
   logic                emit;
   logic                abort7;
   logic                run;

   assign pop = !out_valid_ff || !rsp_stall;
   assign run = head.valid && pop;

   always_comb begin
      ones_in  = ones_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      mode_in  = mode_ff;
      frame_in = frame_ff;
      flag_in  = flag_ff;
      res      = 1'b0;
      res_data = '0;
      res_kind = EV_DATA;
      res_pos  = frame_ff;
      emit     = 1'b0;
      abort7   = 1'b0;

      if (!(mode_ff inside {MODE_LEAD, MODE_FRAME})) begin
         mode_in = MODE_HUNT;
         if (head.flip) begin
            if (ones_ff == 3'd6) begin
               mode_in  = MODE_LEAD;
               frame_in = '0;
               shift_in = '0;
               bits_in  = '0;
               flag_in  = 1'b0;
            end
            ones_in = '0;
         end else if (ones_ff != 3'd7) begin
            ones_in = ones_ff + 1'b1;
         end
      end else begin
         if (head.flip) begin
            // a zero after five ones is stuffing
            if (ones_ff != 3'd5) begin
               if (ones_ff == 3'd6) begin
                  flag_in = 1'b1;
               end
               shift_in = {1'b0, shift_ff[DATA_W-1:1]};
               bits_in  = bits_ff + 1'b1;
            end
            ones_in = '0;
         end else begin
            shift_in = {1'b1, shift_ff[DATA_W-1:1]};
            if (ones_ff >= 3'd6) begin
               ones_in  = 3'd7;
               abort7   = 1'b1;
               mode_in  = MODE_HUNT;
               frame_in = '0;
               if (mode_ff == MODE_FRAME) begin
                  res      = 1'b1;
                  res_kind = EV_ABORT_ONES;
               end
            end else begin
               ones_in = ones_ff + 1'b1;
               bits_in = bits_ff + 1'b1;
            end
         end

         if (!abort7 && bits_in[3]) begin
            if (mode_ff == MODE_LEAD) begin
               bits_in = '0;
               flag_in = 1'b0;
               emit    = (shift_in != FLAG_BYTE);
            end else if (flag_in) begin
               res      = 1'b1;
               res_kind = EV_END;
               mode_in  = MODE_LEAD;
               frame_in = '0;
               bits_in  = '0;
               flag_in  = 1'b0;
            end else begin
               bits_in = '0;
               flag_in = 1'b0;
               emit    = 1'b1;
            end
         end

         if (emit) begin
            res = 1'b1;
            if (frame_ff >= max_frame_bytes) begin
               res_kind = EV_ABORT_LONG;
               mode_in  = MODE_HUNT;
               frame_in = '0;
            end else begin
               res_kind = EV_DATA;
               res_data = shift_in;
               frame_in = frame_ff + 1'b1;
               mode_in  = MODE_FRAME;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (run) begin
         out_valid_in = res;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff      <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         mode_ff      <= MODE_HUNT;
         frame_ff     <= '0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (run) begin
            ones_ff  <= ones_in;
            shift_ff <= shift_in;
            bits_ff  <= bits_in;
            mode_ff  <= mode_in;
            frame_ff <= frame_in;
            flag_ff  <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (run && res) begin
         out_data_ff <= res_data;
         out_kind_ff <= res_kind;
         out_pos_ff  <= res_pos;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_event_kind    = out_kind_ff;
   assign rsp_byte_position = out_pos_ff;

endmodule

`default_nettype wire

// ===== rtl/core/nrzi_hdlc_frame_receiver_core.sv =====
// With the bit queue empty, an accepted line bit passes through the bit queue and then the
// event output register before its event is on rsp_.
// Throughput: one line bit per cycle unless rsp_stall holds the output, set by the back-end decode.
// The bit queue (QUEUE_DEPTH beats) absorbs output stalls; req_stall rises when it is full.
// Synchronous active-high reset clears the control state, empties the queue and loads the
// frame length limit with 271; it is ready for bits on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module nrzi_hdlc_frame_receiver_core
   import nhfr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_line_level,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [DATA_W-1:0]       rsp_data_byte,
   output logic [KIND_W-1:0]       rsp_event_kind,
   output logic [COUNT_W-1:0]      rsp_byte_position,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_max_frame_bytes
);

   logic [COUNT_W-1:0] max_frame_ff;
   nhfr_bit_type       head;
   logic               pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= 10'd271;
      end else if (csr_valid && csr_ready) begin
         max_frame_ff <= csr_max_frame_bytes;
      end
   end

   nhfr_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_line_level (req_line_level),
      .head           (head),
      .pop            (pop)
   );

   nhfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .max_frame_bytes   (max_frame_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_byte_position (rsp_byte_position)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the NRZI HDLC frame receiver core.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import nhfr_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [KIND_W-1:0]  kind;
      logic [COUNT_W-1:0] pos;
   } rx_event_type;

   localparam logic [7:0] FLAG_OCTET     = 8'h7E;
   localparam int         SETTLE_CYCLES  = 16;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         IDLE_PCT       = 26;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_line_level = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [DATA_W-1:0]  rsp_data_byte;
   logic [KIND_W-1:0]  rsp_event_kind;
   logic [COUNT_W-1:0] rsp_byte_position;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_max_frame_bytes = '0;

   nrzi_hdlc_frame_receiver_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_line_level      (req_line_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_byte_position   (rsp_byte_position),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_frame_bytes (csr_max_frame_bytes)
   );

   always #6 clock = ~clock;

   // receiver state mirror
   logic [COUNT_W-1:0] m_limit  = 10'd271;
   logic               m_prev   = 1'b0;
   logic [2:0]         m_ones   = '0;
   logic [7:0]         m_shift  = '0;
   logic [3:0]         m_nbits  = '0;
   logic [1:0]         m_mode   = MODE_HUNT;
   logic [COUNT_W-1:0] m_fbytes = '0;
   logic               m_flag   = 1'b0;

   rx_event_type rx_events_due[$];
   rx_event_type due_head;
   int           fail_count = 0;
   int           line_bits_sent = 0;
   int           quiet_cycles = 0;
   bit           idle_en = 1'b1;

   // line encoder state
   logic tx_level = 1'b0;
   int   tx_ones = 0;

   function automatic void queue_event(input logic [7:0] d, input logic [KIND_W-1:0] k,
                                       input logic [COUNT_W-1:0] p);
      rx_event_type e;
      e.data = d;
      e.kind = k;
      e.pos  = p;
      rx_events_due.push_back(e);
   endfunction

   function automatic void store_octet(input logic [7:0] b);
      if (m_fbytes >= m_limit) begin
         queue_event(8'h00, EV_ABORT_LONG, m_fbytes);
         m_mode   = MODE_HUNT;
         m_fbytes = '0;
      end else begin
         queue_event(b, EV_DATA, m_fbytes);
         m_fbytes = m_fbytes + 1'b1;
         m_mode   = MODE_FRAME;
      end
   endfunction

   function automatic void decode_line_bit(input logic lvl);
      logic       flip;
      logic [7:0] b;
      flip   = (lvl != m_prev);
      m_prev = lvl;
      if (m_mode != MODE_LEAD && m_mode != MODE_FRAME) begin
         m_mode = MODE_HUNT;
         if (flip) begin
            if (m_ones == 3'd6) begin
               m_mode   = MODE_LEAD;
               m_fbytes = '0;
               m_shift  = '0;
               m_nbits  = '0;
               m_flag   = 1'b0;
            end
            m_ones = '0;
         end else if (m_ones < 3'd7) begin
            m_ones = m_ones + 1'b1;
         end
         return;
      end
      if (flip) begin
         // a zero after five ones is a stuffed bit
         if (m_ones != 3'd5) begin
            if (m_ones == 3'd6)
               m_flag = 1'b1;
            m_shift = {1'b0, m_shift[7:1]};
            m_nbits = m_nbits + 1'b1;
         end
         m_ones = '0;
      end else begin
         m_shift = {1'b1, m_shift[7:1]};
         m_ones  = m_ones + 1'b1;
         if (m_ones == 3'd7) begin
            if (m_mode == MODE_FRAME)
               queue_event(8'h00, EV_ABORT_ONES, m_fbytes);
            m_mode   = MODE_HUNT;
            m_fbytes = '0;
            return;
         end
         m_nbits = m_nbits + 1'b1;
      end
      if (m_nbits < 4'd8)
         return;
      b = m_shift;
      if (m_mode == MODE_LEAD) begin
         m_nbits = '0;
         m_flag  = 1'b0;
         if (b != FLAG_OCTET)
            store_octet(b);
         return;
      end
      if (m_flag) begin
         queue_event(8'h00, EV_END, m_fbytes);
         m_mode   = MODE_LEAD;
         m_fbytes = '0;
         m_nbits  = '0;
         m_flag   = 1'b0;
         return;
      end
      m_nbits = '0;
      m_flag  = 1'b0;
      store_octet(b);
   endfunction

   // one line level per beat
   task automatic send_line(input logic lvl);
      while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_line_level <= lvl;
      do @(posedge clock); while (req_stall);
      line_bits_sent++;
      decode_line_bit(lvl);
   endtask

   task automatic send_decoded(input logic b);
      if (!b)
         tx_level = ~tx_level;
      tx_ones = b ? tx_ones + 1 : 0;
      send_line(tx_level);
   endtask

   task automatic send_raw(input logic [15:0] v, input int n);
      for (int i = 0; i < n; i++)
         send_decoded(v[i]);
   endtask

   task automatic send_flag();
      send_raw({8'h00, FLAG_OCTET}, 8);
   endtask

   task automatic send_octet(input logic [7:0] v);
      for (int i = 0; i < 8; i++) begin
         send_decoded(v[i]);
         if (tx_ones == 5)
            send_decoded(1'b0);
      end
   endtask

   task automatic send_frame(input int n_bytes, input int n_open, input bit close);
      repeat (n_open) send_flag();
      repeat (n_bytes) send_octet(8'($urandom_range(0, 255)));
      if (close)
         send_flag();
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (rx_events_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [COUNT_W-1:0] lim);
      drain_results();
      csr_valid           <= 1'b1;
      csr_max_frame_bytes <= lim;
      do @(posedge clock); while (!csr_ready);
      m_limit = lim;
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_frame();
      send_flag();
      send_octet(8'h00);
      send_octet(8'hFF);
      send_octet(8'h7E);
      send_octet(8'h5A);
      send_flag();
      // closing flag doubles as the next opening flag
      send_octet(8'h81);
      send_flag();
   endtask

   task automatic test_leading_flags();
      send_flag();
      send_flag();
      send_flag();
      send_octet(8'h3C);
      send_flag();
   endtask

   task automatic test_seven_ones();
      send_flag();
      send_octet(8'hA5);
      send_raw(16'h00FF, 7);
      send_flag();
      send_raw(16'h00FF, 7);
      // eight ones then a zero is no flag
      send_raw(16'h00FF, 8);
      send_raw(16'h0000, 1);
      send_octet(8'h96);
      send_raw(16'h03FF, 10);
      send_raw(16'h0000, 2);
   endtask

   task automatic test_flag_in_first_byte();
      send_flag();
      send_raw(16'h003F, 8);
      send_octet(8'h11);
      send_flag();
   endtask

   task automatic test_length_limit();
      write_frame_limit(10'd1);
      send_frame(3, 1, 1'b1);
      send_frame(1, 1, 1'b1);
      write_frame_limit(10'd2);
      send_frame(3, 2, 1'b1);
   endtask

   task automatic test_max_limit();
      write_frame_limit(10'd1023);
      send_frame(16, 1, 1'b1);
      send_frame(2, 1, 1'b1);
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      int          n_bytes;
      int          stop_at;
      int          cap;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_frame_limit(10'd3);
            1: write_frame_limit(COUNT_W'($urandom_range(1, 16)));
            2: write_frame_limit(10'd512);
            3: write_frame_limit(10'd1);
            4: write_frame_limit(10'd271);
            default: write_frame_limit(COUNT_W'($urandom_range(1, 40)));
         endcase
         idle_en = (ph != 2);
         stop_at = line_bits_sent + 260;
         while (line_bits_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            cap  = (m_limit < 40) ? int'(m_limit) + 2 : 40;
            if ($urandom_range(0, 6) == 0)
               n_bytes = int'($urandom_range(0, cap));
            else
               n_bytes = int'($urandom_range(0, 8));
            if (pick < 65) begin
               send_frame(n_bytes, int'($urandom_range(1, 3)), $urandom_range(0, 3) != 0);
            end else if (pick < 75) begin
               send_frame(int'($urandom_range(0, 4)), 1, 1'b0);
               send_raw(16'hFFFF, int'($urandom_range(7, 10)));
            end else if (pick < 87) begin
               repeat ($urandom_range(1, 24)) send_decoded(1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
               // unstuffed content: stray flags and aborts
               send_flag();
               repeat ($urandom_range(1, 4)) send_raw(16'($urandom_range(0, 255)), 8);
            end else begin
               drain_results();
            end
         end
      end
      idle_en = 1'b1;
   endtask

   always @(posedge clock)
      rsp_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rx_events_due.size() == 0) begin
            $error("unexpected beat: data_byte %0h event_kind %0d byte_position %0d",
                   rsp_data_byte, rsp_event_kind, rsp_byte_position);
            fail_count++;
         end else begin
            due_head = rx_events_due.pop_front();
            if (rsp_data_byte !== due_head.data) begin
               $error("data_byte: expected %0h, actual %0h", due_head.data, rsp_data_byte);
               fail_count++;
            end
            if (rsp_event_kind !== due_head.kind) begin
               $error("event_kind: expected %0d, actual %0d", due_head.kind, rsp_event_kind);
               fail_count++;
            end
            if (rsp_byte_position !== due_head.pos) begin
               $error("byte_position: expected %0d, actual %0d",
                      due_head.pos, rsp_byte_position);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_frame();
      test_leading_flags();
      test_seven_ones();
      test_flag_in_first_byte();
      test_length_limit();
      test_max_limit();
      test_random_traffic();
      drain_results();
      if (rx_events_due.size() != 0) begin
         $error("%0d results never arrived", rx_events_due.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
